### sv/greedy_gated_assignment_defines.svh
// assertion macros for the checker file
`ifndef GREEDY_GATED_ASSIGNMENT_DEFINES_SVH
`define GREEDY_GATED_ASSIGNMENT_DEFINES_SVH

// same-cycle implication, checked out of reset
`define GGA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define GGA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### sv/gga_pkg.sv
`default_nettype none

package gga_pkg;

  // matrix bounds
  localparam int MAX_TRACKS = 32;
  localparam int MAX_MEAS   = 32;
  localparam int DEPTH      = MAX_TRACKS * MAX_MEAS;

  // field and counter widths
  localparam int COST_W    = 24;
  localparam int TRK_W     = $clog2(MAX_TRACKS);
  localparam int MEAS_W    = $clog2(MAX_MEAS);
  localparam int CNT_W     = 6;
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int LOAD_W    = ADDR_W + 1;
  localparam int CFG_IDX_W = 2;

  localparam logic [COST_W-1:0] GATE_RESET = '1;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GATE   = 2'd0,
    REG_TRACKS = 2'd1,
    REG_MEAS   = 2'd2
  } cfg_reg_t;

  // sequencer states
  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SCAN,
    ST_DRAIN
  } state_t;

endpackage

`default_nettype wire

### sv/greedy_gated_assignment.sv
// Load: one cost beat per cycle, start is taken whenever busy is low.
// Assignment: after the last-marked beat, busy stays high through the scan of the matrix
// (T tracks, M measurements) and the drain state, one cost store read and one compare per cycle.
// The result for track t strobes after the compare of its last column is registered.
// Results cannot be stalled; one strobe cycle per track, in track order.
// Synchronous active-low reset: empty frame, used map clear, registers default.
`default_nettype none

module greedy_gated_assignment (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [gga_pkg::COST_W-1:0]    in_cost,
  input  wire logic                          in_last_cost,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [gga_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [gga_pkg::COST_W-1:0]    cfg_data,
  output logic                               out_strobe,
  output logic [gga_pkg::TRK_W-1:0]          out_track_index,
  output logic [gga_pkg::MEAS_W-1:0]         out_measurement_index,
  output logic                               out_assigned,
  output logic                               out_last_track
);
  import gga_pkg::*;

  // configuration registers
  logic [COST_W-1:0] gate_r;
  logic [CNT_W-1:0]  tracks_cfg_r;
  logic [CNT_W-1:0]  meas_cfg_r;

  // sequencer and frame state
  state_t             state_r, state_nxt;
  logic [LOAD_W-1:0]  loaded_r, loaded_nxt;
  logic [MAX_MEAS-1:0] used_r, used_nxt;
  logic [ADDR_W-1:0]  pos_r, pos_nxt;
  logic [MEAS_W-1:0]  j_r, j_nxt;
  logic [TRK_W-1:0]   i_r, i_nxt;

  // read stage
  logic               rd_valid_r, rd_valid_nxt;
  logic               rd_first_r, rd_last_r, rd_tlast_r, rd_ok_r;
  logic [MEAS_W-1:0]  rd_j_r;
  logic [TRK_W-1:0]   rd_i_r;
  logic [COST_W-1:0]  rd_data_r;

  // running best of the current track
  logic [COST_W-1:0]  best_r;
  logic [MEAS_W-1:0]  best_j_r;
  logic               found_r;

  logic               out_strobe_r;

  logic [COST_W-1:0]  mem [DEPTH];

  logic [CNT_W-1:0]   tracks_c, meas_c;
  logic [LOAD_W-1:0]  total_c;
  logic               load_acc, load_we, issue;
  logic               col_last, trk_last;
  logic [COST_W-1:0]  base_best, cur_best;
  logic [MEAS_W-1:0]  base_j, cur_j;
  logic               base_found, cur_found, take;

  // counts clamped to 1..max
  always_comb begin
    if (tracks_cfg_r == '0) begin
      tracks_c = CNT_W'(1);
    end else if (tracks_cfg_r > CNT_W'(MAX_TRACKS)) begin
      tracks_c = CNT_W'(MAX_TRACKS);
    end else begin
      tracks_c = tracks_cfg_r;
    end
    if (meas_cfg_r == '0) begin
      meas_c = CNT_W'(1);
    end else if (meas_cfg_r > CNT_W'(MAX_MEAS)) begin
      meas_c = CNT_W'(MAX_MEAS);
    end else begin
      meas_c = meas_cfg_r;
    end
  end

  assign total_c   = LOAD_W'(tracks_c) * LOAD_W'(meas_c);
  assign busy      = (state_r != ST_LOAD);
  assign cfg_ready = 1'b1;
  assign load_acc  = start && !busy;
  assign load_we   = load_acc && (loaded_r < total_c);
  assign issue     = (state_r == ST_SCAN);
  assign col_last  = (CNT_W'(j_r) == meas_c - CNT_W'(1));
  assign trk_last  = (CNT_W'(i_r) == tracks_c - CNT_W'(1));

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gate_r       <= GATE_RESET;
      tracks_cfg_r <= CNT_W'(1);
      meas_cfg_r   <= CNT_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_GATE:   gate_r       <= cfg_data;
        REG_TRACKS: tracks_cfg_r <= cfg_data[CNT_W-1:0];
        REG_MEAS:   meas_cfg_r   <= cfg_data[CNT_W-1:0];
        default:    ;
      endcase
    end
  end

  // cost store: one write port for loading, one registered read for the scan
  always_ff @(posedge clk) begin
    if (load_we) begin
      mem[loaded_r[ADDR_W-1:0]] <= in_cost;
    end
    rd_data_r <= mem[pos_r];
  end

  // shared compare unit: lowest unused cost below the gate, first column wins
  always_comb begin
    base_best  = rd_first_r ? gate_r : best_r;
    base_j     = rd_first_r ? '0 : best_j_r;
    base_found = rd_first_r ? 1'b0 : found_r;
    take       = rd_ok_r && !used_r[rd_j_r] && (rd_data_r < base_best);
    cur_best   = take ? rd_data_r : base_best;
    cur_j      = take ? rd_j_r : base_j;
    cur_found  = take || base_found;
  end

  // sequencer next state
  always_comb begin
    state_nxt    = state_r;
    loaded_nxt   = loaded_r;
    used_nxt     = used_r;
    pos_nxt      = pos_r;
    j_nxt        = j_r;
    i_nxt        = i_r;
    rd_valid_nxt = 1'b0;
    case (state_r)
      ST_LOAD: begin
        if (load_we) begin
          loaded_nxt = loaded_r + LOAD_W'(1);
        end
        if (load_acc && in_last_cost) begin
          state_nxt = ST_SCAN;
          pos_nxt   = '0;
          j_nxt     = '0;
          i_nxt     = '0;
        end
      end
      ST_SCAN: begin
        rd_valid_nxt = 1'b1;
        pos_nxt      = pos_r + ADDR_W'(1);
        if (col_last) begin
          j_nxt = '0;
          i_nxt = i_r + TRK_W'(1);
          if (trk_last) begin
            state_nxt = ST_DRAIN;
          end
        end else begin
          j_nxt = j_r + MEAS_W'(1);
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_LOAD;
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
    // mark the winner of a finished track
    if (rd_valid_r && rd_last_r && cur_found) begin
      used_nxt[cur_j] = 1'b1;
    end
    // new frame
    if (state_r == ST_DRAIN) begin
      loaded_nxt = '0;
      used_nxt   = '0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_LOAD;
      loaded_r     <= '0;
      used_r       <= '0;
      rd_valid_r   <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      loaded_r     <= loaded_nxt;
      used_r       <= used_nxt;
      rd_valid_r   <= rd_valid_nxt;
      out_strobe_r <= rd_valid_r && rd_last_r;
    end
  end

  // scan counters and read-stage tags
  always_ff @(posedge clk) begin
    pos_r <= pos_nxt;
    j_r   <= j_nxt;
    i_r   <= i_nxt;
    if (issue) begin
      rd_first_r <= (j_r == '0);
      rd_last_r  <= col_last;
      rd_tlast_r <= trk_last;
      rd_ok_r    <= ({1'b0, pos_r} < loaded_r);
      rd_j_r     <= j_r;
      rd_i_r     <= i_r;
    end
  end

  // running best and result register
  always_ff @(posedge clk) begin
    if (rd_valid_r) begin
      best_r   <= cur_best;
      best_j_r <= cur_j;
      found_r  <= cur_found;
    end
    if (rd_valid_r && rd_last_r) begin
      out_track_index       <= rd_i_r;
      out_measurement_index <= cur_found ? cur_j : '0;
      out_assigned          <= cur_found;
      out_last_track        <= rd_tlast_r;
    end
  end

  assign out_strobe = out_strobe_r;

endmodule

`default_nettype wire

### sv/gga_checker.sv
`default_nettype none
`include "greedy_gated_assignment_defines.svh"

module gga_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        start,
  input wire logic                        busy,
  input wire logic                        in_last_cost,
  input wire logic                        out_strobe,
  input wire logic [gga_pkg::MEAS_W-1:0]  out_measurement_index,
  input wire logic                        out_assigned,
  input wire logic                        out_last_track
);
  import gga_pkg::*;

  // unassigned results report column zero
  `GGA_ASSERT_NOW(a_unassigned_zero, out_strobe && !out_assigned, out_measurement_index == '0, "unassigned result with nonzero column")

  // a last beat starts the assignment pass
  `GGA_ASSERT_NEXT(a_last_goes_busy, start && !busy && in_last_cost, busy, "no assignment after last beat")

  // the final track ends the burst of results
  `GGA_ASSERT_NEXT(a_no_strobe_after_last, out_strobe && out_last_track, !out_strobe, "result after final track")

  // earlier tracks report while the pass is still running
  `GGA_ASSERT_NOW(a_mid_results_busy, out_strobe && !out_last_track, busy, "mid-frame result while idle")

endmodule

bind greedy_gated_assignment gga_checker u_gga_checker (.*);

`default_nettype wire

### tb/testbench.sv
module testbench;
  import gga_pkg::*;

  localparam int QUIET_LIMIT  = 6000;
  localparam int RANDOM_BEATS = 250;

  // one track result as it leaves the block
  typedef struct packed {
    logic [TRK_W-1:0]  trk;
    logic [MEAS_W-1:0] col;
    logic              hit;
    logic              last_row;
  } track_result_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic [COST_W-1:0]   in_cost = '0;
  logic                in_last_cost = 1'b0;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  cfg_reg_t            cfg_index = REG_GATE;
  logic [COST_W-1:0]   cfg_data = '0;
  logic                out_strobe;
  logic [TRK_W-1:0]    out_track_index;
  logic [MEAS_W-1:0]   out_measurement_index;
  logic                out_assigned;
  logic                out_last_track;

  // assignment predictor state
  logic [COST_W-1:0]   cost_mem [DEPTH];
  int                  loaded_n = 0;
  logic [MAX_MEAS-1:0] taken_cols = '0;
  logic [COST_W-1:0]   gate_q = GATE_RESET;
  logic [CNT_W-1:0]    tracks_raw = 6'd1;
  logic [CNT_W-1:0]    meas_raw = 6'd1;
  track_result_t       pending_tracks[$];

  // run bookkeeping
  int mismatches = 0;
  int results_checked = 0;
  int beats_taken = 0;
  int frames_taken = 0;
  int quiet_cycles = 0;
  int burst_left = 0;
  bit gaps_on = 1'b1;
  logic [COST_W-1:0] cur_gate = GATE_RESET;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  greedy_gated_assignment dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .start                 (start),
    .busy                  (busy),
    .in_cost               (in_cost),
    .in_last_cost          (in_last_cost),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data),
    .out_strobe            (out_strobe),
    .out_track_index       (out_track_index),
    .out_measurement_index (out_measurement_index),
    .out_assigned          (out_assigned),
    .out_last_track        (out_last_track)
  );

  // count registers: zero acts as one, above the maximum acts as the maximum
  function automatic int eff_count(input logic [CNT_W-1:0] v, input int limit);
    if (v == '0) return 1;
    if (int'(v) > limit) return limit;
    return int'(v);
  endfunction

  // store one cost beat; on the last beat run the greedy pass
  function automatic void load_cost(input logic [COST_W-1:0] c, input logic lst);
    int nt;
    int nm;
    int t;
    int j;
    int pos;
    int best_col;
    bit found;
    logic [COST_W-1:0] best;
    track_result_t r;
    nt = eff_count(tracks_raw, MAX_TRACKS);
    nm = eff_count(meas_raw, MAX_MEAS);
    if (loaded_n < nt * nm) begin
      cost_mem[loaded_n] = c;
      loaded_n++;
    end
    if (!lst) return;
    for (t = 0; t < nt; t++) begin
      best = gate_q;
      best_col = 0;
      found = 1'b0;
      for (j = 0; j < nm; j++) begin
        pos = t * nm + j;
        if (pos < loaded_n && !taken_cols[j] && cost_mem[pos] < best) begin
          best = cost_mem[pos];
          best_col = j;
          found = 1'b1;
        end
      end
      if (found) taken_cols[best_col] = 1'b1;
      r.trk = TRK_W'(t);
      r.col = found ? MEAS_W'(best_col) : '0;
      r.hit = found;
      r.last_row = (t + 1 == nt);
      pending_tracks.insert(pending_tracks.size(), r);
    end
    loaded_n = 0;
    taken_cols = '0;
  endfunction

  // watch every handshake: results, cost beats, register writes
  always @(posedge clk) begin : monitor
    track_result_t got;
    track_result_t want;
    if (rst_n) begin
      if (out_strobe) begin
        got.trk = out_track_index;
        got.col = out_measurement_index;
        got.hit = out_assigned;
        got.last_row = out_last_track;
        if (pending_tracks.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: track %0d col %0d assigned %b last %b",
                     got.trk, got.col, got.hit, got.last_row);
        end else begin
          want = pending_tracks.pop_front();
          results_checked++;
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp track %0d col %0d asg %b last %b, got %0d %0d %b %b",
                       want.trk, want.col, want.hit, want.last_row,
                       got.trk, got.col, got.hit, got.last_row);
          end
        end
      end
      if (start && !busy) begin
        load_cost(in_cost, in_last_cost);
        beats_taken++;
        if (in_last_cost) frames_taken++;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_GATE:   gate_q = cfg_data;
          REG_TRACKS: tracks_raw = cfg_data[CNT_W-1:0];
          REG_MEAS:   meas_raw = cfg_data[CNT_W-1:0];
          default:    ;
        endcase
      end
      quiet_cycles <= (out_strobe || (start && !busy) || (cfg_valid && cfg_ready)) ?
                      0 : quiet_cycles + 1;
    end
  end

  // stall detector
  initial begin : watchdog
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("greedy_gated_assignment test failed");
    $finish;
  end

  // one cost beat, with bursty gaps before it
  task automatic send_cost(input logic [COST_W-1:0] c, input bit lst);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if (gaps_on) gap = $urandom_range(1, 6);
    end
    burst_left--;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_cost <= c;
    in_last_cost <= lst;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic send_matrix(input logic [COST_W-1:0] vals[$], input bit mark_last);
    int i;
    for (i = 0; i < vals.size(); i++)
      send_cost(vals[i], mark_last && (i == vals.size() - 1));
  endtask

  // stop sending and let every outstanding track result drain
  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (pending_tracks.size() != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [COST_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // write all three registers; count registers get junk in the unused bits
  task automatic configure(input logic [COST_W-1:0] gate, input logic [CNT_W-1:0] trk,
                           input logic [CNT_W-1:0] cols);
    logic [COST_W-CNT_W-1:0] junk_t;
    logic [COST_W-CNT_W-1:0] junk_m;
    junk_t = (COST_W-CNT_W)'($urandom);
    junk_m = (COST_W-CNT_W)'($urandom);
    write_reg(REG_GATE, gate);
    write_reg(REG_TRACKS, {junk_t, trk});
    write_reg(REG_MEAS, {junk_m, cols});
    cfg_valid <= 1'b0;
    cur_gate = gate;
  endtask

  function automatic logic [COST_W-1:0] rand_cost(input logic [COST_W-1:0] gate);
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return gate;
      3:       return (gate == '0) ? '0 : gate - 1'b1;
      4:       return COST_W'(64 + $urandom_range(0, 3));
      5, 6:    return COST_W'($urandom_range(0, int'(gate)));
      default: return COST_W'($urandom);
    endcase
  endfunction

  // reset defaults: gate all ones, one track, one measurement
  task automatic test_reset_values();
    logic [COST_W-1:0] q[$];
    q = '{24'hFFFFFE};
    send_matrix(q, 1'b1);
    q = '{24'hFFFFFF};
    send_matrix(q, 1'b1);
    wait_idle();
  endtask

  // ties go to the lowest column, used columns are skipped
  task automatic test_ties_and_extremes();
    logic [COST_W-1:0] q[$];
    configure(24'hFFFFFF, 6'd2, 6'd3);
    q = '{24'h000000, 24'hFFFFFF, 24'h000000, 24'h000000, 24'h000000, 24'h000005};
    send_matrix(q, 1'b1);
    q = '{24'h800000, 24'h7FFFFF, 24'h555555, 24'hAAAAAA, 24'h000001, 24'h000001};
    send_matrix(q, 1'b1);
    wait_idle();
  endtask

  // gate is a strict bound
  task automatic test_gate_bound();
    logic [COST_W-1:0] q[$];
    configure(24'd0, 6'd1, 6'd2);
    q = '{24'd0, 24'd0};
    send_matrix(q, 1'b1);
    wait_idle();
    configure(24'd100, 6'd1, 6'd2);
    q = '{24'd100, 24'd99};
    send_matrix(q, 1'b1);
    wait_idle();
  endtask

  // beats past a full matrix are dropped, the last mark still fires
  task automatic test_overfull();
    logic [COST_W-1:0] q[$];
    configure(24'hFFFFFF, 6'd1, 6'd2);
    q = '{24'd9, 24'd8, 24'd1, 24'd0};
    send_matrix(q, 1'b1);
    wait_idle();
  endtask

  // entries not loaded this frame are never assigned
  task automatic test_missing_entries();
    logic [COST_W-1:0] q[$];
    configure(24'hFFFFFF, 6'd2, 6'd2);
    q = '{24'd3};
    send_matrix(q, 1'b1);
    wait_idle();
  endtask

  // registers changed between beats of one frame
  task automatic test_mid_frame_registers();
    logic [COST_W-1:0] q[$];
    configure(24'hFFFFFF, 6'd2, 6'd2);
    q = '{24'd7, 24'd6};
    send_matrix(q, 1'b0);
    wait_idle();
    configure(24'hFFFFFF, 6'd1, 6'd3);
    q = '{24'd5};
    send_matrix(q, 1'b1);
    wait_idle();
  endtask

  // full width rows and columns, clamped counts
  task automatic test_largest_sizes();
    logic [COST_W-1:0] q[$];
    int j;
    configure(24'hFFFFFF, 6'd0, 6'd63);
    q = {};
    for (j = 0; j < MAX_MEAS; j++) q.insert(q.size(), COST_W'(1000 - j));
    send_matrix(q, 1'b1);
    wait_idle();
    configure(COST_W'($urandom), 6'd63, 6'd1);
    q = {};
    for (j = 0; j < MAX_TRACKS; j++) q.insert(q.size(), rand_cost(cur_gate));
    send_matrix(q, 1'b1);
    wait_idle();
    configure(24'h400000, 6'd32, 6'd32);
    q = {};
    for (j = 0; j < 80; j++) q.insert(q.size(), rand_cost(cur_gate));
    send_matrix(q, 1'b1);
    wait_idle();
  endtask

  // random frames, mostly well formed, some short or overfull
  task automatic test_random_frames();
    logic [COST_W-1:0] q[$];
    logic [COST_W-1:0] gate;
    logic [CNT_W-1:0] trk;
    logic [CNT_W-1:0] cols;
    int nt;
    int nm;
    int len;
    int j;
    int sent;
    bit first;
    sent = 0;
    first = 1'b1;
    while (sent < RANDOM_BEATS) begin
      if (first || $urandom_range(0, 2) == 0) begin
        wait_idle();
        case ($urandom_range(0, 5))
          0:       gate = '1;
          1:       gate = '0;
          2:       gate = COST_W'($urandom);
          default: gate = COST_W'($urandom_range(64, 4096));
        endcase
        case ($urandom_range(0, 9))
          0:       trk = '0;
          1:       trk = CNT_W'($urandom_range(33, 63));
          default: trk = CNT_W'($urandom_range(1, 6));
        endcase
        case ($urandom_range(0, 9))
          0:       cols = '0;
          1:       cols = CNT_W'($urandom_range(33, 63));
          default: cols = CNT_W'($urandom_range(1, 6));
        endcase
        // keep big frames rare and short
        if (eff_count(trk, MAX_TRACKS) * eff_count(cols, MAX_MEAS) > 64) begin
          if (eff_count(trk, MAX_TRACKS) > 6) cols = CNT_W'($urandom_range(1, 2));
          else trk = CNT_W'($urandom_range(1, 2));
        end
        configure(gate, trk, cols);
        gaps_on = ($urandom_range(0, 3) != 0);
        first = 1'b0;
      end
      nt = eff_count(trk, MAX_TRACKS);
      nm = eff_count(cols, MAX_MEAS);
      case ($urandom_range(0, 9))
        0:       len = $urandom_range(1, nt * nm);
        1:       len = nt * nm + $urandom_range(1, 3);
        default: len = nt * nm;
      endcase
      q = {};
      for (j = 0; j < len; j++) q.insert(q.size(), rand_cost(cur_gate));
      send_matrix(q, 1'b1);
      sent += (len < nt * nm) ? len : nt * nm;
    end
    wait_idle();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_values();
    test_ties_and_extremes();
    test_gate_bound();
    test_overfull();
    test_missing_entries();
    test_mid_frame_registers();
    test_largest_sizes();
    test_random_frames();
    wait_idle();
    repeat (40) @(posedge clk);
    if (pending_tracks.size() != 0) begin
      mismatches++;
      $display("%0d track results never arrived", pending_tracks.size());
    end
    $display("covered %0d cost beats over %0d frames, %0d track results compared",
             beats_taken, frames_taken, results_checked);
    $display("mismatches: %0d", mismatches);
    if (mismatches == 0) begin
      $display("greedy_gated_assignment test passed");
    end else begin
      $display("greedy_gated_assignment test failed");
    end
    $finish;
  end

endmodule
